FILE: sv/pdu_pkg.sv
// Shared types and fixed field widths for the perceptron dot/update block.
// No dependencies; every other file refers to it by scoped names.
package pdu_pkg;

    // Fixed field widths
    localparam int KIND_BITS   = 2;
    localparam int INDEX_BITS  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_BITS   = 16;
    localparam int SUM_BITS    = 48;
    localparam int FRAC_BITS   = 12;
    // error * sample is 32 bits, floor-shifted by the fraction bits
    localparam int DELTA_BITS  = 2 * SAMPLE_BITS - FRAC_BITS;

    // Input kind codes
    localparam logic [KIND_BITS-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PREDICT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_TRAIN   = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // Work carried to the back end
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PREDICT,
        OP_TRAIN
    } op_t;

    typedef struct packed {
        op_t  op;
        logic idx_ok;   // index addresses a real weight
        logic last;     // closes a predict vector
    } item_ctrl_t;

endpackage

FILE: sv/pdu_front.sv
// Front end: classifies incoming transactions and precomputes the train delta.
// Depends on pdu_pkg.
module pdu_front #(
    parameter int NUM_WEIGHTS = 256,
    parameter int ADDR_BITS   = 8
) (
    input  logic                                   s_valid,
    input  logic        [pdu_pkg::KIND_BITS-1:0]   s_kind,
    input  logic        [pdu_pkg::INDEX_BITS-1:0]  s_element_index,
    input  logic signed [pdu_pkg::SAMPLE_BITS-1:0] s_data_value,
    input  logic signed [pdu_pkg::SAMPLE_BITS-1:0] s_scaled_error,
    input  logic        [pdu_pkg::SLOT_BITS-1:0]   s_result_slot,
    input  logic                                   s_last,
    output logic                                   push_valid,
    output pdu_pkg::item_ctrl_t                    push_ctrl,
    output logic        [ADDR_BITS-1:0]            push_addr,
    output logic signed [pdu_pkg::SAMPLE_BITS-1:0] push_sample,
    output logic signed [pdu_pkg::DELTA_BITS-1:0]  push_delta,
    output logic        [pdu_pkg::SLOT_BITS-1:0]   push_slot
);

    logic                                   idx_ok;
    logic                                   keep;
    logic signed [2*pdu_pkg::SAMPLE_BITS-1:0] err_x_sample;

    assign idx_ok = (32'(s_element_index) < NUM_WEIGHTS);

    // Classify: loads/trains to missing weights and unknown kinds are dropped
    always_comb begin
        push_ctrl.op     = pdu_pkg::OP_PREDICT;
        push_ctrl.idx_ok = idx_ok;
        push_ctrl.last   = 1'b0;
        keep             = 1'b0;
        case (s_kind)
            pdu_pkg::KIND_LOAD: begin
                push_ctrl.op = pdu_pkg::OP_LOAD;
                keep         = idx_ok;
            end
            pdu_pkg::KIND_PREDICT: begin
                push_ctrl.op   = pdu_pkg::OP_PREDICT;
                push_ctrl.last = s_last;
                keep           = 1'b1;
            end
            pdu_pkg::KIND_TRAIN: begin
                push_ctrl.op = pdu_pkg::OP_TRAIN;
                keep         = idx_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_valid = s_valid && keep;

    // Train delta does not depend on the weight: floor(err * sample / 2^12)
    assign err_x_sample = (2*pdu_pkg::SAMPLE_BITS)'(s_scaled_error)
                        * (2*pdu_pkg::SAMPLE_BITS)'(s_data_value);
    assign push_delta   = pdu_pkg::DELTA_BITS'(err_x_sample >>> pdu_pkg::FRAC_BITS);

    assign push_addr   = ADDR_BITS'(s_element_index);
    assign push_sample = s_data_value;
    assign push_slot   = s_result_slot;

endmodule

FILE: sv/pdu_queue.sv
// Two-entry queue decoupling the front end from the back end.
// Depends on pdu_pkg for depth and pointer widths.
module pdu_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output logic [DATA_BITS-1:0] pop_data
);

    logic [DATA_BITS-1:0]          entry_reg [pdu_pkg::QUEUE_DEPTH];
    logic [pdu_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [pdu_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [pdu_pkg::QCNT_BITS-1:0] count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != pdu_pkg::QCNT_BITS'(pdu_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + pdu_pkg::QCNT_BITS'(1);
                2'b01:   count_reg <= count_reg - pdu_pkg::QCNT_BITS'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: sv/pdu_back.sv
// Back end: weight memory, read/update stage, product stage, accumulator and
// output register. Depends on pdu_pkg.
module pdu_back #(
    parameter int NUM_WEIGHTS = 256,
    parameter int VALUE_BITS  = 16,
    parameter int ADDR_BITS   = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  pdu_pkg::item_ctrl_t                    pop_ctrl,
    input  logic        [ADDR_BITS-1:0]            pop_addr,
    input  logic signed [pdu_pkg::SAMPLE_BITS-1:0] pop_sample,
    input  logic signed [pdu_pkg::DELTA_BITS-1:0]  pop_delta,
    input  logic        [pdu_pkg::SLOT_BITS-1:0]   pop_slot,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pdu_pkg::SUM_BITS-1:0]    m_dot_sum,
    output logic        [pdu_pkg::SLOT_BITS-1:0]   m_slot_out
);

    localparam int PROD_BITS = pdu_pkg::SAMPLE_BITS + VALUE_BITS;
    localparam int EXT_BITS  =
        ((VALUE_BITS > pdu_pkg::DELTA_BITS) ? VALUE_BITS : pdu_pkg::DELTA_BITS) + 1;
    localparam logic signed [EXT_BITS-1:0] W_MAX =
        EXT_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_BITS-1:0] W_MIN = -W_MAX - 1;

    function automatic logic signed [VALUE_BITS-1:0] sat_weight(
        input logic signed [EXT_BITS-1:0] v
    );
        logic signed [EXT_BITS-1:0] c;
        c = v;
        if (v > W_MAX) c = W_MAX;
        if (v < W_MIN) c = W_MIN;
        return VALUE_BITS'(c);
    endfunction

    // Weight memory
    logic signed [VALUE_BITS-1:0] weight_mem [NUM_WEIGHTS];
    logic signed [VALUE_BITS-1:0] rd_data_reg;

    // Read/update stage
    logic                                   b_valid_reg;
    pdu_pkg::item_ctrl_t                    b_ctrl_reg;
    logic        [ADDR_BITS-1:0]            b_addr_reg;
    logic signed [pdu_pkg::SAMPLE_BITS-1:0] b_sample_reg;
    logic signed [pdu_pkg::DELTA_BITS-1:0]  b_delta_reg;
    logic        [pdu_pkg::SLOT_BITS-1:0]   b_slot_reg;

    // Last write, forwarded to the item whose read raced it
    logic                         fwd_valid_reg;
    logic [ADDR_BITS-1:0]         fwd_addr_reg;
    logic signed [VALUE_BITS-1:0] fwd_data_reg;

    // Product stage
    logic                                 c_valid_reg;
    logic                                 c_last_reg;
    logic signed [PROD_BITS-1:0]          c_prod_reg;
    logic        [pdu_pkg::SLOT_BITS-1:0] c_slot_reg;

    logic        [pdu_pkg::SUM_BITS-1:0] running_sum_reg;
    logic        [pdu_pkg::SUM_BITS-1:0] sum_next;
    logic signed [pdu_pkg::SUM_BITS-1:0] prod_ext;

    logic                                m_valid_reg;
    logic signed [pdu_pkg::SUM_BITS-1:0] m_dot_sum_reg;
    logic        [pdu_pkg::SLOT_BITS-1:0] m_slot_reg;

    logic                         adv;
    logic                         fwd_hit;
    logic signed [VALUE_BITS-1:0] w_mem;
    logic signed [VALUE_BITS-1:0] w_eff;
    logic signed [EXT_BITS-1:0]   upd_operand;
    logic signed [VALUE_BITS-1:0] wr_data;
    logic                         wr_en;
    logic signed [PROD_BITS-1:0]  prod;

    // Whole pipe moves when the output register is free or being drained
    assign adv       = !m_valid_reg || m_ready;
    assign pop_ready = adv;

    // Weight seen by the item in the update stage
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == b_addr_reg);
    assign w_mem   = fwd_hit ? fwd_data_reg : rd_data_reg;
    assign w_eff   = b_ctrl_reg.idx_ok ? w_mem : '0;

    // Shared saturating update for loads and trains
    assign upd_operand = (b_ctrl_reg.op == pdu_pkg::OP_LOAD)
                       ? EXT_BITS'(b_sample_reg)
                       : EXT_BITS'(w_mem) + EXT_BITS'(b_delta_reg);
    assign wr_data = sat_weight(upd_operand);
    assign wr_en   = adv && b_valid_reg && (b_ctrl_reg.op != pdu_pkg::OP_PREDICT);

    assign prod = PROD_BITS'(b_sample_reg) * PROD_BITS'(w_eff);

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            weight_mem[b_addr_reg] <= wr_data;
        end
        if (adv) begin
            rd_data_reg <= weight_mem[pop_addr];
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            b_ctrl_reg   <= pop_ctrl;
            b_addr_reg   <= pop_addr;
            b_sample_reg <= pop_sample;
            b_delta_reg  <= pop_delta;
            b_slot_reg   <= pop_slot;
            fwd_addr_reg <= b_addr_reg;
            fwd_data_reg <= wr_data;
            c_last_reg   <= b_ctrl_reg.last;
            c_prod_reg   <= prod;
            c_slot_reg   <= b_slot_reg;
        end
    end

    // Accumulate and close the vector
    assign prod_ext = pdu_pkg::SUM_BITS'(c_prod_reg);
    assign sum_next = running_sum_reg + prod_ext;

    // Control and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg     <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            c_valid_reg     <= 1'b0;
            running_sum_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else if (adv) begin
            b_valid_reg   <= pop_valid;
            fwd_valid_reg <= wr_en;
            c_valid_reg   <= b_valid_reg && (b_ctrl_reg.op == pdu_pkg::OP_PREDICT);
            m_valid_reg   <= 1'b0;
            if (c_valid_reg) begin
                if (c_last_reg) begin
                    running_sum_reg <= '0;
                    m_valid_reg     <= 1'b1;
                    m_dot_sum_reg   <= sum_next;
                    m_slot_reg      <= c_slot_reg;
                end else begin
                    running_sum_reg <= sum_next;
                end
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_dot_sum  = m_dot_sum_reg;
    assign m_slot_out = m_slot_reg;

endmodule

FILE: sv/perceptron_dot_and_update.sv
// Perceptron weight store with streamed dot product and delta-rule update.
// Input transactions (s_*): kind 0 loads a weight, kind 1 multiplies the
// sample by the indexed weight and accumulates, kind 2 adds the floor-scaled
// error * sample to the weight with saturation. Kind 3 is dropped.
// A predict transaction with s_last set emits the 48-bit Q24 sum on m_* with
// its result slot and clears the accumulator.
// Throughput: one transaction per cycle sustained unless the output holds the
// back end; the weight memory has one read and one write port, and a
// read-after-update to the same index is forwarded, so back-to-back
// trains/predicts on one weight need no bubble. A result passes through the
// queue, memory read/update stage, product stage and accumulate/output.
// The back end holds while a result waits and m_ready is low; the two-entry
// queue keeps taking input until it fills, then s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and pipe and clears the
// accumulator; weights are not cleared and must be loaded before use.
// Depends on pdu_pkg, pdu_front, pdu_queue, pdu_back.
module perceptron_dot_and_update #(
    parameter int NUM_WEIGHTS = 256,
    parameter int VALUE_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic        [pdu_pkg::KIND_BITS-1:0]   s_kind,
    input  logic        [pdu_pkg::INDEX_BITS-1:0]  s_element_index,
    input  logic signed [pdu_pkg::SAMPLE_BITS-1:0] s_data_value,
    input  logic signed [pdu_pkg::SAMPLE_BITS-1:0] s_scaled_error,
    input  logic        [pdu_pkg::SLOT_BITS-1:0]   s_result_slot,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pdu_pkg::SUM_BITS-1:0]    m_dot_sum,
    output logic        [pdu_pkg::SLOT_BITS-1:0]   m_slot_out
);

    localparam int ADDR_BITS = $clog2(NUM_WEIGHTS);
    localparam int Q_BITS    = $bits(pdu_pkg::item_ctrl_t) + ADDR_BITS
                             + pdu_pkg::SAMPLE_BITS + pdu_pkg::DELTA_BITS
                             + pdu_pkg::SLOT_BITS;

    logic                                   push_valid;
    logic                                   push_ready;
    pdu_pkg::item_ctrl_t                    push_ctrl;
    logic        [ADDR_BITS-1:0]            push_addr;
    logic signed [pdu_pkg::SAMPLE_BITS-1:0] push_sample;
    logic signed [pdu_pkg::DELTA_BITS-1:0]  push_delta;
    logic        [pdu_pkg::SLOT_BITS-1:0]   push_slot;
    logic        [Q_BITS-1:0]               push_data;

    logic                                   pop_valid;
    logic                                   pop_ready;
    logic        [Q_BITS-1:0]               pop_data;
    pdu_pkg::item_ctrl_t                    pop_ctrl;
    logic        [ADDR_BITS-1:0]            pop_addr;
    logic signed [pdu_pkg::SAMPLE_BITS-1:0] pop_sample;
    logic signed [pdu_pkg::DELTA_BITS-1:0]  pop_delta;
    logic        [pdu_pkg::SLOT_BITS-1:0]   pop_slot;

    // Every transaction is taken while the queue has room; dropped ones vanish
    assign s_ready = push_ready;

    pdu_front #(
        .NUM_WEIGHTS (NUM_WEIGHTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_front (
        .s_valid         (s_valid),
        .s_kind          (s_kind),
        .s_element_index (s_element_index),
        .s_data_value    (s_data_value),
        .s_scaled_error  (s_scaled_error),
        .s_result_slot   (s_result_slot),
        .s_last          (s_last),
        .push_valid      (push_valid),
        .push_ctrl       (push_ctrl),
        .push_addr       (push_addr),
        .push_sample     (push_sample),
        .push_delta      (push_delta),
        .push_slot       (push_slot)
    );

    assign push_data = {push_ctrl, push_addr, push_sample, push_delta, push_slot};

    pdu_queue #(
        .DATA_BITS (Q_BITS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {pop_ctrl, pop_addr, pop_sample, pop_delta, pop_slot} = pop_data;

    pdu_back #(
        .NUM_WEIGHTS (NUM_WEIGHTS),
        .VALUE_BITS  (VALUE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_ctrl   (pop_ctrl),
        .pop_addr   (pop_addr),
        .pop_sample (pop_sample),
        .pop_delta  (pop_delta),
        .pop_slot   (pop_slot),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_dot_sum  (m_dot_sum),
        .m_slot_out (m_slot_out)
    );

endmodule
